### rtl/scct_pkg.sv
// Shared types and constants for the sector cache clock tag engine.
`timescale 1ns / 1ps

package scct_pkg;

  // Default slot count
  localparam int unsigned SLOTS_DEF = 64;

  // Field widths
  localparam int unsigned SECTOR_W = 32;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned IN_DATA_W  = 40;  // sector + dirty_in, padded to bytes
  localparam int unsigned OUT_DATA_W = 40;  // slot + old_sector + old_dirty, padded

  // Operation codes carried in the input tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 3'd0,
    KIND_WRITE = 3'd1,
    KIND_ADD   = 3'd2,
    KIND_EVICT = 3'd3,
    KIND_TAKE  = 3'd4
  } kind_e;

  // One tag memory word; valid flags live in flops outside the memory
  typedef struct packed {
    logic [SECTOR_W-1:0] tag;
    logic                dirty;
    logic                ref_bit;
  } entry_t;

endpackage

### rtl/sector_cache_clock_tags.sv
// Tag and clock-replacement engine of a fully associative sector cache.
// Flow: an accepted word is registered, each slot's tag word is read through the registered read
// port and then evaluated, and the result is registered; a lookup miss scans all SLOTS slots.
// The tag memory is scanned one slot per cycle through its single read port; a clock sweep
// visits at most SLOTS + 1 slots. One operation is in flight at a time, so a new word is taken
// only after the last result is registered. Reset clears all valid flags, the clock hand and the
// handshake state; the tag memory is not cleared, its contents only count behind a valid flag.
`timescale 1ns / 1ps

module sector_cache_clock_tags #(
  parameter int unsigned SLOTS = scct_pkg::SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input words
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [scct_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // sector[31:0], dirty_in[32]
  input  logic [scct_pkg::KIND_W-1:0]     s_axis_tuser,  // kind[2:0]
  // result words
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [scct_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // slot[5:0], old_sector[37:6],
                                                         // old_dirty[38]
  output logic                            m_axis_tuser   // found[0]
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);
  localparam int unsigned RES_W = scct_pkg::SLOT_W + scct_pkg::SECTOR_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  // Control state
  state_e            state_q,   state_d;
  logic [AW-1:0]     hand_q,    hand_d;
  logic [SLOTS-1:0]  valid_q,   valid_d;
  logic              pv_q,      pv_d;
  logic              m_valid_q, m_valid_d;

  // Payload registers
  scct_pkg::kind_e                kind_q;
  logic [scct_pkg::SECTOR_W-1:0]  sector_q;
  logic                           dirty_in_q;
  logic [AW-1:0]                  ptr_q, ptr_d;
  logic [AW-1:0]                  paddr_q;
  scct_pkg::entry_t               rdata_q;
  logic [scct_pkg::OUT_DATA_W-1:0] m_data_q, hold_data_q;
  logic                           m_found_q, hold_found_q;

  // Tag memory
  scct_pkg::entry_t mem [SLOTS];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  scct_pkg::entry_t mem_wdata;
  logic             rd_en;

  // Evaluation of the slot whose word just came out of memory
  logic                          v;
  logic                          term;
  logic                          res_found;
  logic [AW-1:0]                 res_slot;
  logic [scct_pkg::SECTOR_W-1:0] res_sector;
  logic                          res_dirty;
  logic [AW+5:0]                 slot_ext;
  logic [scct_pkg::OUT_DATA_W-1:0] res_data;
  logic                          out_free;
  logic                          accept;
  logic [AW-1:0]                 p_next;
  logic [AW-1:0]                 ptr_inc;
  logic [AW-1:0]                 ptr_dec;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign v        = valid_q[paddr_q];
  assign p_next   = (paddr_q == LAST) ? '0 : paddr_q + AW'(1);
  assign ptr_inc  = (ptr_q == LAST) ? '0 : ptr_q + AW'(1);
  assign ptr_dec  = (ptr_q == '0) ? LAST : ptr_q - AW'(1);
  assign slot_ext = {6'b0, res_slot};

  // Result word packing
  assign res_data = {{(scct_pkg::OUT_DATA_W - RES_W){1'b0}}, res_dirty, res_sector,
                     slot_ext[5:0]};

  // Per-slot evaluation, memory write-back and flag updates
  always_comb begin
    term       = 1'b0;
    res_found  = 1'b0;
    res_slot   = '0;
    res_sector = '0;
    res_dirty  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = paddr_q;
    mem_wdata  = rdata_q;
    valid_d    = valid_q;
    hand_d     = hand_q;
    if (state_q == ST_SCAN && pv_q) begin
      case (kind_q)
        scct_pkg::KIND_READ, scct_pkg::KIND_WRITE: begin
          if (v && rdata_q.tag == sector_q) begin
            term              = 1'b1;
            res_found         = 1'b1;
            res_slot          = paddr_q;
            mem_we            = 1'b1;
            mem_wdata.ref_bit = 1'b1;
            mem_wdata.dirty   = rdata_q.dirty || (kind_q == scct_pkg::KIND_WRITE);
          end else if (paddr_q == LAST) begin
            term = 1'b1;
          end
        end
        scct_pkg::KIND_ADD, scct_pkg::KIND_EVICT: begin
          if (v && rdata_q.ref_bit) begin
            // second chance: clear referenced and move on
            mem_we            = 1'b1;
            mem_wdata.ref_bit = 1'b0;
          end else begin
            term              = 1'b1;
            res_found         = v;
            res_slot          = paddr_q;
            res_sector        = v ? rdata_q.tag : '0;
            res_dirty         = v && rdata_q.dirty;
            valid_d[paddr_q]  = 1'b0;
            hand_d            = paddr_q;
            if (kind_q == scct_pkg::KIND_ADD) begin
              mem_we            = 1'b1;
              mem_wdata.tag     = sector_q;
              mem_wdata.dirty   = dirty_in_q;
              mem_wdata.ref_bit = 1'b1;
              valid_d[paddr_q]  = 1'b1;
              hand_d            = p_next;
            end
          end
        end
        scct_pkg::KIND_TAKE: begin
          if (v && rdata_q.dirty) begin
            term             = 1'b1;
            res_found        = 1'b1;
            res_slot         = paddr_q;
            res_sector       = rdata_q.tag;
            res_dirty        = 1'b1;
            valid_d[paddr_q] = 1'b0;
          end else if (paddr_q == '0) begin
            term = 1'b1;
          end
        end
        default: begin
          term = 1'b1;
        end
      endcase
    end
  end

  // Sequencer: start address, scan pointer, result hand-off
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    pv_d      = pv_q;
    rd_en     = 1'b0;
    m_valid_d = m_valid_q && !m_axis_tready;
    case (state_q)
      ST_IDLE: begin
        pv_d = 1'b0;
        if (accept) begin
          state_d = ST_SCAN;
          case (scct_pkg::kind_e'(s_axis_tuser))
            scct_pkg::KIND_ADD, scct_pkg::KIND_EVICT: ptr_d = hand_q;
            scct_pkg::KIND_TAKE:                      ptr_d = LAST;
            default:                                  ptr_d = '0;
          endcase
        end
      end
      ST_SCAN: begin
        if (term) begin
          pv_d    = 1'b0;
          state_d = out_free ? ST_IDLE : ST_HOLD;
          if (out_free) begin
            m_valid_d = 1'b1;
          end
        end else begin
          rd_en = 1'b1;
          pv_d  = 1'b1;
          ptr_d = (kind_q == scct_pkg::KIND_TAKE) ? ptr_dec : ptr_inc;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_found_q;

  // Control registers and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      hand_q    <= '0;
      valid_q   <= '0;
      pv_q      <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_found_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      hand_q    <= hand_d;
      valid_q   <= valid_d;
      pv_q      <= pv_d;
      m_valid_q <= m_valid_d;
      if (state_q == ST_SCAN && term && out_free) begin
        m_data_q  <= res_data;
        m_found_q <= res_found;
      end else if (state_q == ST_HOLD && out_free) begin
        m_data_q  <= hold_data_q;
        m_found_q <= hold_found_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (rd_en) begin
      paddr_q <= ptr_q;
    end
    if (accept) begin
      kind_q     <= scct_pkg::kind_e'(s_axis_tuser);
      sector_q   <= s_axis_tdata[scct_pkg::SECTOR_W-1:0];
      dirty_in_q <= s_axis_tdata[scct_pkg::SECTOR_W];
    end
    if (state_q == ST_SCAN && term && !out_free) begin
      hold_data_q  <= res_data;
      hold_found_q <= res_found;
    end
  end

  // Tag memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[ptr_q];
    end
  end

endmodule
